// ===== hw/rtl/mme_pkg.sv =====
// Shared constants, types and op codes for the modularity matrix engine.
// No dependencies; imported by the engine and its checker.
package mme_pkg;

  localparam int MAX_NODES   = 64;
  localparam int WEIGHT_BITS = 8;
  localparam int FRAC_BITS   = 16;

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_NODES * MAX_NODES;
  localparam int NODE_W  = 7;
  localparam int IN_WT_W = 8;
  localparam int OP_W    = 2;
  localparam int DEG_W   = 16;
  localparam int TOT_W   = 20;
  localparam int VALUE_W = 31;
  localparam int PROD_W  = 2 * DEG_W;
  localparam int DEN_W   = TOT_W + 1;
  localparam int QUO_W   = VALUE_W;
  localparam int SAT_SH  = QUO_W - FRAC_BITS;
  localparam int CMP_W   = DEN_W + SAT_SH;
  localparam int DIFF_W  = VALUE_W + 2;
  localparam int STEP_W  = $clog2(QUO_W);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  localparam longint WMAX   = (longint'(1) << WEIGHT_BITS) - 1;
  localparam longint HI_L   = WMAX * (longint'(1) << FRAC_BITS);
  localparam longint LO_L   = -(longint'(MAX_NODES) * WMAX * (longint'(1) << FRAC_BITS));

  localparam logic signed [DIFF_W-1:0] VAL_HI = DIFF_W'(HI_L);
  localparam logic signed [DIFF_W-1:0] VAL_LO = DIFF_W'(LO_L);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WR,
    ST_Q_RD,
    ST_Q_MUL,
    ST_Q_CHK,
    ST_Q_DIV,
    ST_Q_FIN,
    ST_Q_OUT
  } state_e;

endpackage

// ===== hw/rtl/modularity_matrix_engine.sv =====
// Modularity matrix engine top level: weight store, degree store, edge total,
// query datapath with an iterative divider. Depends on mme_pkg.
//
// Takes one item at a time. A load reads the old weight and row degree, then
// writes both back. A query with a good index and a nonzero edge total reads
// the weight and both degrees, multiplies, then runs the radix-2 divider
// that produces the 31 quotient bits of k_row*k_col*2^16/(2M) one per cycle;
// a query that saturates early skips the divider, and one with a bad index or
// a zero total goes straight to the output. A clear, and reset, run a pass
// over the weight store, one entry a cycle, during which no item is taken;
// configuration writes are taken at any time. Results sit in an output
// register, so a finished result may wait while the next item is taken.
module modularity_matrix_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mme_pkg::NODE_W-1:0]      cfg_wdata_i,    // node_count
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mme_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // row[5:0], col[11:6], weight[19:12]
  input  logic [mme_pkg::OP_W-1:0]        s_axis_tuser,   // op[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mme_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // value[30:0]
  output logic [mme_pkg::OUT_USER_W-1:0]  m_axis_tuser    // no_edges[0], bad_index[1]
);
  import mme_pkg::*;

  // control
  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [TOT_W-1:0]    edge_total_q, edge_total_d;
  logic [NODE_W-1:0]   node_count_q, node_count_d;
  logic                out_valid_q, out_valid_d;

  // payload
  logic [IDX_W-1:0]       row_q, row_d, col_q, col_d;
  logic [WEIGHT_BITS-1:0] wt_q, wt_d;
  logic [WEIGHT_BITS-1:0] a_q, a_d;
  logic [DEG_W-1:0]       kr_q, kr_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [DEN_W-1:0]       rem_q, rem_d;
  logic [QUO_W-1:0]       sh_q, sh_d;
  logic [VALUE_W-1:0]     res_value_q, res_value_d;
  logic                   res_none_q, res_none_d, res_bad_q, res_bad_d;
  logic [VALUE_W-1:0]     out_value_q, out_value_d;
  logic                   out_none_q, out_none_d, out_bad_q, out_bad_d;

  // memories
  logic [WEIGHT_BITS-1:0] wmem [DEPTH];
  logic [DEG_W-1:0]       dmem [MAX_NODES];
  logic                   wmem_we, dmem_we;
  logic [ADDR_W-1:0]      wmem_waddr, wmem_raddr;
  logic [WEIGHT_BITS-1:0] wmem_wdata, wrd_q;
  logic [IDX_W-1:0]       dmem_waddr, dmem_raddr;
  logic [DEG_W-1:0]       dmem_wdata, drd_q;

  // input fields
  logic [IDX_W-1:0]   in_row, in_col;
  logic [IN_WT_W-1:0] in_wt;
  op_e                in_op;
  logic               accept, in_ok;

  // arithmetic
  logic [DEN_W-1:0]         den;
  logic [DEN_W:0]           trial;
  logic                     qbit;
  logic signed [DIFF_W-1:0] diff;

  assign in_row = s_axis_tdata[IDX_W-1:0];
  assign in_col = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_wt  = s_axis_tdata[2*IDX_W+IN_WT_W-1:2*IDX_W];
  assign in_op  = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_ok = ({1'b0, in_row} < node_count_q) && ({1'b0, in_col} < node_count_q);

  assign den   = {edge_total_q, 1'b0};
  assign trial = {rem_q, sh_q[QUO_W-1]};
  assign qbit  = (trial >= {1'b0, den});
  assign diff  = $signed(DIFF_W'({a_q, FRAC_BITS'(0)})) - $signed(DIFF_W'(sh_q));

  assign wmem_raddr = {in_row, in_col};
  assign dmem_raddr = (state_q == ST_Q_RD) ? col_q : in_row;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    edge_total_d = edge_total_q;
    node_count_d = cfg_we_i ? cfg_wdata_i : node_count_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    row_d        = row_q;
    col_d        = col_q;
    wt_d         = wt_q;
    a_d          = a_q;
    kr_d         = kr_q;
    prod_d       = prod_q;
    rem_d        = rem_q;
    sh_d         = sh_q;
    res_value_d  = res_value_q;
    res_none_d   = res_none_q;
    res_bad_d    = res_bad_q;
    out_value_d  = out_value_q;
    out_none_d   = out_none_q;
    out_bad_d    = out_bad_q;
    wmem_we      = 1'b0;
    wmem_waddr   = {row_q, col_q};
    wmem_wdata   = wt_q;
    dmem_we      = 1'b0;
    dmem_waddr   = row_q;
    dmem_wdata   = drd_q + DEG_W'(wt_q) - DEG_W'(wrd_q);

    case (state_q)
      ST_CLEAR: begin
        wmem_we    = 1'b1;
        wmem_waddr = cnt_q;
        wmem_wdata = '0;
        dmem_we    = (cnt_q[ADDR_W-1:IDX_W] == '0);
        dmem_waddr = cnt_q[IDX_W-1:0];
        dmem_wdata = '0;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          row_d = in_row;
          col_d = in_col;
          wt_d  = in_wt[WEIGHT_BITS-1:0];
          case (in_op)
            OP_LOAD: begin
              if (in_ok) begin
                state_d = ST_LD_WR;
              end
            end
            OP_QUERY: begin
              res_value_d = '0;
              res_none_d  = (edge_total_q == '0);
              res_bad_d   = !in_ok;
              state_d     = (in_ok && edge_total_q != '0) ? ST_Q_RD : ST_Q_OUT;
            end
            OP_CLEAR: begin
              edge_total_d = '0;
              cnt_d        = '0;
              state_d      = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_LD_WR: begin
        // old weight and row degree arrived from the reads issued at accept
        wmem_we = 1'b1;
        dmem_we = 1'b1;
        if (row_q < col_q) begin
          edge_total_d = edge_total_q + TOT_W'(wt_q) - TOT_W'(wrd_q);
        end
        state_d = ST_IDLE;
      end
      ST_Q_RD: begin
        a_d     = wrd_q;
        kr_d    = drd_q;
        state_d = ST_Q_MUL;
      end
      ST_Q_MUL: begin
        prod_d  = PROD_W'(kr_q) * PROD_W'(drd_q);
        state_d = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        // quotient of 2^31 or more always lands below the low clamp
        if (CMP_W'(prod_q) >= {den, SAT_SH'(0)}) begin
          res_value_d = VAL_LO[VALUE_W-1:0];
          state_d     = ST_Q_OUT;
        end else begin
          rem_d   = DEN_W'(prod_q[PROD_W-1:SAT_SH]);
          sh_d    = {prod_q[SAT_SH-1:0], FRAC_BITS'(0)};
          cnt_d   = '0;
          state_d = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        rem_d = qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        sh_d  = {sh_q[QUO_W-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[STEP_W-1:0] == STEP_W'(QUO_W - 1)) begin
          state_d = ST_Q_FIN;
        end
      end
      ST_Q_FIN: begin
        if (diff < VAL_LO) begin
          res_value_d = VAL_LO[VALUE_W-1:0];
        end else if (diff > VAL_HI) begin
          res_value_d = VAL_HI[VALUE_W-1:0];
        end else begin
          res_value_d = diff[VALUE_W-1:0];
        end
        state_d = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_value_d = res_value_q;
          out_none_d  = res_none_q;
          out_bad_d   = res_bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      edge_total_q <= '0;
      node_count_q <= NODE_W'(MAX_NODES);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      edge_total_q <= edge_total_d;
      node_count_q <= node_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    wt_q        <= wt_d;
    a_q         <= a_d;
    kr_q        <= kr_d;
    prod_q      <= prod_d;
    rem_q       <= rem_d;
    sh_q        <= sh_d;
    res_value_q <= res_value_d;
    res_none_q  <= res_none_d;
    res_bad_q   <= res_bad_d;
    out_value_q <= out_value_d;
    out_none_q  <= out_none_d;
    out_bad_q   <= out_bad_d;
  end

  always_ff @(posedge clk_i) begin
    if (wmem_we) begin
      wmem[wmem_waddr] <= wmem_wdata;
    end
    wrd_q <= wmem[wmem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dmem_we) begin
      dmem[dmem_waddr] <= dmem_wdata;
    end
    drd_q <= dmem[dmem_raddr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_value_q);
  assign m_axis_tuser  = {out_bad_q, out_none_q};

endmodule

// ===== hw/rtl/mme_checker.sv =====
// Port-level checks for the modularity matrix engine, bound to the top level.
// Depends on mme_pkg.
module mme_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mme_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [mme_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import mme_pkg::*;

  logic signed [DIFF_W-1:0] value_ext;

  assign value_ext = $signed({{(DIFF_W-VALUE_W){m_axis_tdata[VALUE_W-1]}},
                              m_axis_tdata[VALUE_W-1:0]});

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // flagged results carry a zero value
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]) |-> m_axis_tdata == '0)
    else $error("flagged result with nonzero value");

  // saturation bounds
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> value_ext >= VAL_LO && value_ext <= VAL_HI &&
      m_axis_tdata[OUT_DATA_W-1] == 1'b0)
    else $error("result value out of range");

  // no result shows up the cycle right after an item is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind modularity_matrix_engine mme_checker u_mme_checker (.*);
